>>> rtl/lcg_random_with_range_modes_assert.svh
// Assertion macros for the random generator block.
// Used by the top level; needs clk and rst in the scope of each use.
`ifndef LCG_RANDOM_WITH_RANGE_MODES_ASSERT_SVH
`define LCG_RANDOM_WITH_RANGE_MODES_ASSERT_SVH
`ifndef SYNTH
`define LCGR_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (rst) prop) \
  else $error("lcgr assertion failed");
`define LCGR_NEVER(lbl, cond) `LCGR_ASSERT(lbl, !(cond))
`else
`define LCGR_ASSERT(lbl, prop)
`define LCGR_NEVER(lbl, cond)
`endif
`endif

>>> rtl/lcgr_pkg.sv
// Shared constants and types of the random generator block.
// No dependencies.
package lcgr_pkg;

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;

  localparam logic [2:0] OP_RAW     = 3'd0;
  localparam logic [2:0] OP_RANGE   = 3'd1;
  localparam logic [2:0] OP_BETWEEN = 3'd2;
  localparam logic [2:0] OP_LOTTERY = 3'd3;
  localparam logic [2:0] OP_SAMPLE  = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_THR  = 5'b00010,
    ST_LCG  = 5'b00100,
    ST_MOD  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

endpackage

>>> rtl/lcgr_cfg_if.sv
// Configuration write channel of the random generator block.
// No dependencies.
interface lcgr_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/lcgr_in_if.sv
// Request channel of the random generator block.
// No dependencies.
interface lcgr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] range_a;
  logic [31:0] range_b;
  logic [16:0] rate_fraction;
  logic [31:0] accuracy;
  logic [6:0]  pick_count;

  modport source (output valid, output operation, output range_a, output range_b,
                  output rate_fraction, output accuracy, output pick_count, input ready);
  modport sink (input valid, input operation, input range_a, input range_b,
                input rate_fraction, input accuracy, input pick_count, output ready);
endinterface

>>> rtl/lcgr_out_if.sv
// Result channel of the random generator block.
// No dependencies.
interface lcgr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        win;
  logic [5:0]  slot;
  logic        last;

  modport source (output valid, output value, output win, output slot, output last,
                  input ready);
  modport sink (input valid, input value, input win, input slot, input last,
                output ready);
endinterface

>>> rtl/lcg_random_with_range_modes.sv
// Top level of the three-step LCG random generator with five draw modes.
// Depends on lcgr_pkg, the lcgr_*_if interfaces and the assertion header.
`include "lcg_random_with_range_modes_assert.svh"

// One item at a time. A draw is three LCG steps, each a bit-serial constant
// multiply; modes that reduce the draw add a restoring modulo, one quotient
// bit per cycle. Lottery adds a serial multiply for the threshold. Cases
// that need no draw skip these steps. Sampling draws once per scanned index
// and stalls while a result waits. The result register lets a new request be
// accepted while the previous result is still waiting to be taken.
module lcg_random_with_range_modes import lcgr_pkg::*; #(
  parameter int          MAX_PICKS        = 64,
  parameter logic [31:0] MAX_SAMPLE_RANGE = 32'd65536
) (
  input  logic      clk,
  input  logic      rst,
  lcgr_cfg_if.sink  cfg,
  lcgr_in_if.sink   cmd,
  lcgr_out_if.source res
);

  localparam logic [6:0] PICK_MAX = 7'(MAX_PICKS);

  state_t      state;
  logic [2:0]  op;
  logic [31:0] base;
  logic [31:0] div_n;
  logic [15:0] rate_sh;
  logic [47:0] prod;
  logic [31:0] running_seed;
  logic [31:0] mul_acc;
  logic [31:0] mul_sh;
  logic [4:0]  bit_cnt;
  logic [1:0]  lcg_step;
  logic [30:0] draw_val;
  logic [31:0] rem;
  logic [6:0]  remaining;
  logic [31:0] scan_index;
  logic [31:0] span;
  logic [31:0] res_value;
  logic        res_win;
  logic [5:0]  res_slot;
  logic        res_last;

  // request decode
  logic        a_gt_b;
  logic [31:0] diff;
  logic [31:0] lower;
  logic [31:0] n_sat;
  logic [6:0]  cnt_sat;
  always_comb begin
    a_gt_b  = cmd.range_a > cmd.range_b;
    diff    = a_gt_b ? cmd.range_a - cmd.range_b : cmd.range_b - cmd.range_a;
    lower   = a_gt_b ? cmd.range_b : cmd.range_a;
    n_sat   = (cmd.range_a > MAX_SAMPLE_RANGE) ? MAX_SAMPLE_RANGE : cmd.range_a;
    cnt_sat = (cmd.pick_count > PICK_MAX) ? PICK_MAX : cmd.pick_count;
  end

  // serial datapaths
  logic [47:0] prod_next;
  logic [31:0] acc_next;
  logic [31:0] seed_new;
  logic [30:0] draw_next;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic [31:0] rem_next;
  logic        emit_go;
  always_comb begin
    prod_next = {prod[46:0], 1'b0} + (rate_sh[15] ? {16'd0, div_n} : 48'd0);
    acc_next  = mul_acc + (LCG_MUL[bit_cnt] ? mul_sh : 32'd0);
    seed_new  = acc_next + LCG_ADD;
    draw_next = (lcg_step == 2'd0) ? {20'd0, seed_new[26:16]}
                                   : {draw_val[20:0], seed_new[25:16]};
    rem_sh    = {rem, draw_val[bit_cnt]};
    rem_sub   = rem_sh - {1'b0, div_n};
    rem_next  = (rem_sh >= {1'b0, div_n}) ? rem_sub[31:0] : rem_sh[31:0];
    emit_go   = !res.valid || res.ready;
  end

  assign cmd.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (res.valid && res.ready) begin
      res.valid <= 1'b0;
    end
    case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          op        <= cmd.operation;
          res_value <= 32'd0;
          res_win   <= 1'b0;
          res_slot  <= 6'd0;
          res_last  <= 1'b1;
          mul_acc   <= 32'd0;
          mul_sh    <= running_seed;
          bit_cnt   <= 5'd0;
          lcg_step  <= 2'd0;
          case (cmd.operation)
            OP_RAW: begin
              state <= ST_LCG;
            end
            OP_RANGE: begin
              div_n <= cmd.range_a;
              base  <= 32'd0;
              state <= (cmd.range_a <= 32'd1) ? ST_EMIT : ST_LCG;
            end
            OP_BETWEEN: begin
              div_n     <= diff;
              base      <= lower;
              res_value <= lower;
              state     <= (diff <= 32'd1) ? ST_EMIT : ST_LCG;
            end
            OP_LOTTERY: begin
              div_n   <= cmd.accuracy;
              rate_sh <= cmd.rate_fraction[15:0];
              prod    <= 48'd0;
              bit_cnt <= 5'd15;
              if (cmd.rate_fraction == 17'd0) begin
                state <= ST_EMIT;
              end else if (cmd.rate_fraction[16]) begin
                res_win <= 1'b1;
                state   <= ST_EMIT;
              end else begin
                state <= ST_THR;
              end
            end
            OP_SAMPLE: begin
              remaining  <= cnt_sat;
              scan_index <= 32'd0;
              span       <= n_sat;
              div_n      <= n_sat;
              state      <= (cnt_sat == 7'd0 || n_sat == 32'd0) ? ST_IDLE : ST_LCG;
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
      end
      // threshold = rate * accuracy, one rate bit per cycle
      ST_THR: begin
        prod    <= prod_next;
        rate_sh <= {rate_sh[14:0], 1'b0};
        bit_cnt <= bit_cnt - 5'd1;
        if (bit_cnt == 5'd0) begin
          bit_cnt <= 5'd0;
          if (div_n <= 32'd1) begin
            res_win <= (prod_next[47:16] != 32'd0);
            state   <= ST_EMIT;
          end else begin
            state <= ST_LCG;
          end
        end
      end
      // seed * LCG_MUL, one multiplier bit per cycle
      ST_LCG: begin
        mul_acc <= acc_next;
        mul_sh  <= {mul_sh[30:0], 1'b0};
        bit_cnt <= bit_cnt + 5'd1;
        if (bit_cnt == 5'd31) begin
          running_seed <= seed_new;
          draw_val     <= draw_next;
          mul_acc      <= 32'd0;
          mul_sh       <= seed_new;
          lcg_step     <= lcg_step + 2'd1;
          if (lcg_step == 2'd2) begin
            if (op == OP_RAW) begin
              res_value <= {1'b0, draw_next};
              state     <= ST_EMIT;
            end else begin
              rem     <= 32'd0;
              bit_cnt <= 5'd30;
              state   <= ST_MOD;
            end
          end
        end
      end
      // draw mod div_n, one quotient bit per cycle
      ST_MOD: begin
        rem     <= rem_next;
        bit_cnt <= bit_cnt - 5'd1;
        if (bit_cnt == 5'd0) begin
          bit_cnt  <= 5'd0;
          lcg_step <= 2'd0;
          mul_acc  <= 32'd0;
          mul_sh   <= running_seed;
          state    <= ST_EMIT;
          case (op)
            OP_RANGE: begin
              res_value <= rem_next;
            end
            OP_BETWEEN: begin
              res_value <= rem_next + base;
            end
            OP_LOTTERY: begin
              res_win <= (rem_next < prod[47:16]);
            end
            OP_SAMPLE: begin
              if (rem_next < {25'd0, remaining}) begin
                res_value <= scan_index;
                res_slot  <= 6'(remaining - 7'd1);
                res_last  <= (remaining == 7'd1) || (span == 32'd1);
              end else begin
                // skip this index and draw again
                scan_index <= scan_index + 32'd1;
                span       <= span - 32'd1;
                div_n      <= span - 32'd1;
                state      <= ST_LCG;
              end
            end
            default: begin
              state <= ST_EMIT;
            end
          endcase
        end
      end
      // hand the result to the output register when it is free
      ST_EMIT: begin
        if (emit_go) begin
          res.valid <= 1'b1;
          res.value <= res_value;
          res.win   <= res_win;
          res.slot  <= res_slot;
          res.last  <= res_last;
          state     <= ST_IDLE;
          if (op == OP_SAMPLE) begin
            remaining <= remaining - 7'd1;
            if (!res_last) begin
              scan_index <= scan_index + 32'd1;
              span       <= span - 32'd1;
              div_n      <= span - 32'd1;
              bit_cnt    <= 5'd0;
              lcg_step   <= 2'd0;
              mul_acc    <= 32'd0;
              mul_sh     <= running_seed;
              state      <= ST_LCG;
            end
          end
        end
      end
      default: begin
        state <= ST_IDLE;
      end
    endcase
    if (cfg.valid) begin
      running_seed <= cfg.data;
    end
    if (rst) begin
      state        <= ST_IDLE;
      res.valid    <= 1'b0;
      running_seed <= 32'd1;
      remaining    <= 7'd0;
      scan_index   <= 32'd0;
    end
  end

  `LCGR_ASSERT(a_lcg_wrap, (state == ST_LCG && bit_cnt == 5'd31 && lcg_step != 2'd2) |=> (state == ST_LCG && bit_cnt == 5'd0))
  `LCGR_ASSERT(a_single_last, (state == ST_EMIT && emit_go && op != OP_SAMPLE) |=> res.last)
  `LCGR_NEVER(a_picks_cap, remaining > PICK_MAX)

endmodule
